// ===== rtl/bta_pkg.sv =====
// Package with shared constants, codes and types for the bit-tree slot allocator.
`timescale 1ns / 1ps
package bta_pkg;

  // Tree geometry: LEAVES slots, one tree level per bit of the slot index.
  localparam int LEAVES = 256;
  localparam int LEVELS = $clog2(LEAVES);
  localparam int SLOT_W = 8;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Every internal node owns one word that holds the bits of its two children.
  localparam int WORDS  = LEAVES - 1;
  localparam int ADDR_W = LEVELS;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_MARK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DESC,
    ST_UP,
    ST_DONE
  } state_t;

  // Word address of the internal node at the given level and offset in that level.
  function automatic logic [ADDR_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [LEVELS-1:0] off);
    logic [ADDR_W:0] base;
    base = (ADDR_W + 1)'(1) << lvl;
    node_addr = ADDR_W'(base - (ADDR_W + 1)'(1) + {1'b0, off});
  endfunction

endpackage

// ===== rtl/bta_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bta_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bit_tree_slot_allocator_core.sv =====
// Bit-tree slot allocator: a sequencer that walks the occupancy tree one level per cycle.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   func, slot_in
//   out      output     out_valid / out_ready slot_out, full_res, was_set
//
// Allocate and a mark of a free slot make LEVELS reads going down the tree and LEVELS
// writes coming back up, through one RAM port pair.
// A mark of a slot already in use skips the way up.
// Allocate on a full tree and the unused code go straight to the result.
// Clear-all and reset both run a sweep over the LEAVES-1 node words of the tree RAM;
// no transaction is accepted during a sweep. A finished result waits in the output
// register while the next transaction is accepted.
`timescale 1ns / 1ps
module bit_tree_slot_allocator_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [bta_pkg::SLOT_W-1:0] slot_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bta_pkg::SLOT_W-1:0] slot_out,
  output logic                       full_res,
  output logic                       was_set
);
  import bta_pkg::*;

  state_t state, state_next;

  logic [LVL_W-1:0]  lvl;
  logic [LEVELS-1:0] off;
  logic [LEVELS-1:0] steer;
  logic              is_alloc;
  logic              cidx;
  logic              cval;
  logic [1:0]        path [LEVELS];
  logic              root;
  logic [ADDR_W-1:0] sweep;
  logic              clr_reply;
  logic [SLOT_W-1:0] res_slot;
  logic              res_full;
  logic              res_was;

  logic              accept;
  logic              last_lvl;
  logic              sweep_last;
  logic              out_free;
  logic              dir;
  logic [LEVELS-1:0] off_step;
  logic [1:0]        wword;
  logic              parent_old;
  logic              parent_new;
  logic              leaf_busy;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [1:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [1:0]        ram_rdata;

  // Tree storage: word k holds the left (bit 0) and right (bit 1) child of node k.
  bta_ram #(
    .WIDTH(2),
    .DEPTH(LEAVES)
  ) u_tree (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared datapath terms.
  assign accept     = in_valid && in_ready;
  assign last_lvl   = (lvl == LVL_W'(LEVELS - 1));
  assign sweep_last = (sweep == ADDR_W'(WORDS - 1));
  assign out_free   = !out_valid || out_ready;
  assign dir        = is_alloc ? ram_rdata[0] : steer[LEVELS-1];
  assign off_step   = {off[LEVELS-2:0], dir};
  assign leaf_busy  = ram_rdata[dir];

  // Child word after the update on the way up, and the parent bit it implies.
  assign wword      = cidx ? {cval, path[0][0]} : {path[0][1], cval};
  assign parent_old = (lvl == '0) ? root : path[1][off[0]];
  always_comb begin
    priority if (&wword) begin
      parent_new = 1'b1;
    end else if (~|wword) begin
      parent_new = 1'b0;
    end else begin
      parent_new = parent_old;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sweep_last) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (func == FUNC_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (func == FUNC_MARK) begin
            state_next = ST_DESC;
          end else if (func == FUNC_ALLOC && !root) begin
            state_next = ST_DESC;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DESC: begin
        if (last_lvl) begin
          state_next = (!is_alloc && leaf_busy) ? ST_DONE : ST_UP;
        end
      end
      ST_UP: begin
        if (lvl == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and tree RAM controls.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = node_addr('0, '0);
      end
      ST_DESC: begin
        if (!last_lvl) begin
          ram_raddr = node_addr(lvl + LVL_W'(1), off_step);
        end
      end
      ST_UP: begin
        ram_we    = 1'b1;
        ram_waddr = node_addr(lvl, off);
        ram_wdata = wword;
      end
      ST_DONE: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      root      <= 1'b0;
      sweep     <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep <= sweep + ADDR_W'(1);
      end
      if (accept && func == FUNC_CLEAR) begin
        root      <= 1'b0;
        sweep     <= '0;
        clr_reply <= 1'b1;
      end
      if (state == ST_UP && lvl == '0) begin
        root <= parent_new;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk registers, path stack and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      lvl      <= '0;
      off      <= '0;
      steer    <= slot_in;
      is_alloc <= (func == FUNC_ALLOC);
      res_slot <= '0;
      res_full <= (func == FUNC_ALLOC) && root;
      res_was  <= 1'b0;
    end

    // Going down: push each word read, step to the chosen child.
    if (state == ST_DESC) begin
      path[0] <= ram_rdata;
      for (int i = 1; i < LEVELS; i++) begin
        path[i] <= path[i-1];
      end
      steer <= {steer[LEVELS-2:0], 1'b0};
      if (last_lvl) begin
        res_slot <= SLOT_W'(off_step);
        res_was  <= !is_alloc && leaf_busy;
        cidx     <= dir;
        cval     <= 1'b1;
      end else begin
        lvl <= lvl + LVL_W'(1);
        off <= off_step;
      end
    end

    // Going up: pop one word per level and carry the new node bit to its parent.
    if (state == ST_UP) begin
      for (int i = 0; i < LEVELS - 1; i++) begin
        path[i] <= path[i+1];
      end
      cval <= parent_new;
      cidx <= off[0];
      off  <= off >> 1;
      lvl  <= lvl - LVL_W'(1);
    end

    if (state == ST_DONE && out_free) begin
      slot_out  <= res_slot;
      full_res  <= res_full;
      was_set   <= res_was;
    end
    if (state == ST_CLEAR && sweep_last && clr_reply) begin
      res_slot <= '0;
      res_full <= 1'b0;
      res_was  <= 1'b0;
    end
  end

  // A full result only comes from a tree whose root is set.
  a_full_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && res_full |-> root)
    else $error("full reported while the root is clear");

  // Clear-all empties the root at once.
  a_clear_root: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_CLEAR |=> !root && state == ST_CLEAR)
    else $error("clear-all did not empty the root");

  // The descent moves down exactly one level per cycle.
  a_desc_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_DESC && !last_lvl |=> state == ST_DESC && lvl == $past(lvl) + LVL_W'(1))
    else $error("descent skipped a level");

  // The ascent ends at the root and then reports.
  a_up_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_UP && lvl == '0 |=> state == ST_DONE)
    else $error("ascent did not finish at the root");

endmodule

// ===== sim/bta_grant_checker.sv =====
// Checker that predicts the slot allocator's grants and compares them with the output channel.
`timescale 1ns / 1ps
module bta_grant_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [bta_pkg::SLOT_W-1:0] slot_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [bta_pkg::SLOT_W-1:0] slot_out,
  input  logic                       full_res,
  input  logic                       was_set,
  output int                         errors,
  output int                         outstanding
);
  import bta_pkg::*;

  localparam int NODES      = 2 * LEAVES - 1;
  localparam int FIRST_LEAF = LEAVES - 1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic              dup;
  } grant_t;

  // Shadow copy of the occupancy tree in heap order.
  logic   occ_bits [0:NODES-1];
  grant_t expected_grants [$];

  // Walk from a changed node to the root and settle every ancestor on the way.
  function automatic void settle_path(input int start);
    int node;
    int par;
    logic l;
    logic r;
    node = start;
    while (node > 0) begin
      par = (node - 1) >> 1;
      l = occ_bits[2 * par + 1];
      r = occ_bits[2 * par + 2];
      if (l && r) begin
        occ_bits[par] = 1'b1;
      end else if (!l && !r) begin
        occ_bits[par] = 1'b0;
      end
      node = par;
    end
  endfunction

  // Apply one transaction to the shadow tree and return the grant it produces.
  function automatic grant_t predict_grant(input logic [1:0] op, input logic [SLOT_W-1:0] s);
    grant_t g;
    int node;
    int leaf;
    g = '0;
    case (op)
      FUNC_ALLOC: begin
        if (occ_bits[0]) begin
          g.full = 1'b1;
        end else begin
          node = 0;
          while (node < FIRST_LEAF) begin
            node = occ_bits[2 * node + 1] ? 2 * node + 2 : 2 * node + 1;
          end
          occ_bits[node] = 1'b1;
          settle_path(node);
          g.slot = SLOT_W'(node - FIRST_LEAF);
        end
      end
      FUNC_MARK: begin
        g.slot = s;
        if (int'(s) >= LEAVES) begin
          g.dup = 1'b1;
        end else begin
          leaf = FIRST_LEAF + int'(s);
          if (occ_bits[leaf]) begin
            g.dup = 1'b1;
          end else begin
            occ_bits[leaf] = 1'b1;
            settle_path(leaf);
          end
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NODES; i++) occ_bits[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  // Compare output transactions first, then record the prediction for a new input.
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      for (int i = 0; i < NODES; i++) occ_bits[i] = 1'b0;
      expected_grants.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected grant slot=%0d full=%0b dup=%0b",
                     $realtime, slot_out, full_res, was_set);
          end
          errors++;
        end else begin
          want = expected_grants.pop_front();
          if (slot_out !== want.slot || full_res !== want.full || was_set !== want.dup) begin
            if (errors < 10) begin
              $display("%0t: grant mismatch: expected slot=%0d full=%0b dup=%0b,",
                       $realtime, want.slot, want.full, want.dup,
                       " got slot=%0d full=%0b dup=%0b", slot_out, full_res, was_set);
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_grants.push_back(predict_grant(func, slot_in));
      end
      outstanding <= expected_grants.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the slot allocator simulation: clock, reset, request and grant traffic, verdict.
`timescale 1ns / 1ps
module testbench;
  import bta_pkg::*;

  localparam logic [1:0] FUNC_NOP    = 2'd3;
  localparam int         NUM_ITEMS   = 800;
  localparam int         CYCLE_LIMIT = 600000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [1:0]        func      = FUNC_ALLOC;
  logic [SLOT_W-1:0] slot_in   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] slot_out;
  logic              full_res;
  logic              was_set;
  int                errors;
  int                outstanding;

  int items_sent    = 0;
  int send_burst    = 0;
  int recv_burst    = 0;
  int results_taken = 0;
  int cycles        = 0;

  bit_tree_slot_allocator_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .slot_in   (slot_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_out  (slot_out),
    .full_res  (full_res),
    .was_set   (was_set)
  );

  bta_grant_checker grant_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .slot_in     (slot_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .slot_out    (slot_out),
    .full_res    (full_res),
    .was_set     (was_set),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long, with bursts of no idling at all.
  function automatic int pick_idle(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      burst = $urandom_range(80, 20);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // Offer one request transaction and wait until it is taken.
  task automatic send(input logic [1:0] op, input logic [SLOT_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    func     <= op;
    slot_in  <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = pick_idle(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every grant already owed has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One random request; marks often aim at a few low slots to hit used ones.
  task automatic random_op(input int alloc_w, input int nop_w, input int clear_w);
    int r;
    logic [SLOT_W-1:0] s;
    r = $urandom_range(99);
    s = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(15)) : SLOT_W'($urandom);
    if (r < alloc_w) begin
      send(FUNC_ALLOC, SLOT_W'($urandom));
    end else if (r < alloc_w + nop_w) begin
      send(FUNC_NOP, SLOT_W'($urandom));
    end else if (r < alloc_w + nop_w + clear_w) begin
      send(FUNC_CLEAR, SLOT_W'($urandom));
    end else begin
      send(FUNC_MARK, s);
    end
  endtask

  // Grant side: random stalls, and one long hold-off so the block backs up.
  initial begin
    int hold_left;
    bit long_done;
    hold_left = 0;
    long_done = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_done && results_taken >= 150) begin
        long_done = 1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        hold_left = pick_idle(recv_burst);
        out_ready <= (hold_left == 0);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Request side and verdict.
  initial begin
    int episode;
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: first allocations, used and unused marks, unused codes, edge slots, clears.
    send(FUNC_ALLOC, 8'h00);
    send(FUNC_ALLOC, 8'hFF);
    send(FUNC_MARK,  8'h00);
    send(FUNC_MARK,  8'hFF);
    send(FUNC_MARK,  8'hFF);
    send(FUNC_MARK,  8'h02);
    send(FUNC_ALLOC, 8'h00);
    send(FUNC_NOP,   8'hFF);
    send(FUNC_NOP,   8'h00);
    send(FUNC_ALLOC, 8'hAA);
    send(FUNC_CLEAR, 8'h55);
    send(FUNC_ALLOC, 8'h00);
    send(FUNC_MARK,  8'h01);
    send(FUNC_ALLOC, 8'h00);
    send(FUNC_MARK,  8'h80);
    send(FUNC_MARK,  8'h7F);
    send(FUNC_ALLOC, 8'h0F);
    send(FUNC_CLEAR, 8'h00);
    send(FUNC_MARK,  8'h00);
    send(FUNC_ALLOC, 8'hF0);
    drain();

    // Random episodes; some fill the tree and keep allocating past full.
    episode = 0;
    while (items_sent < NUM_ITEMS) begin
      send(FUNC_CLEAR, SLOT_W'($urandom));
      if (episode == 0 || episode == 6) begin
        repeat (290) random_op(85, 2, 0);
      end else begin
        len = $urandom_range(60, 8);
        repeat (len) random_op(45, 5, 4);
      end
      if (episode == 3) drain();
      episode++;
    end

    drain();
    repeat (64) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
